### sv/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared constants and helpers for the line segment rectangle clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  // Coordinate format: signed Q12.4
  localparam int CoordW   = 16;
  // Internal exact width: right and bottom edges reach about twice the range
  localparam int IntW     = CoordW + 3;
  // Magnitude of a difference of two internal values
  localparam int MagW     = IntW - 1;
  // Product of two magnitudes
  localparam int ProdW    = 2 * MagW;
  localparam int CntW     = $clog2(ProdW);

  localparam int MaxRounds = 10;
  localparam int RoundW    = $clog2(MaxRounds + 1);

  // Result kinds
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Configuration register indices
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_LEFT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOP    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd3;

  // Region code bits
  localparam int BIT_LEFT   = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_BOTTOM = 2;
  localparam int BIT_TOP    = 3;

  typedef logic signed [IntW-1:0] coord_t;

  function automatic logic [3:0] region_code(coord_t x, coord_t y, coord_t l, coord_t r,
                                             coord_t t, coord_t b);
    logic [3:0] c;
    c = '0;
    if (x < l) c[BIT_LEFT] = 1'b1;
    else if (x > r) c[BIT_RIGHT] = 1'b1;
    if (y < t) c[BIT_TOP] = 1'b1;
    else if (y > b) c[BIT_BOTTOM] = 1'b1;
    return c;
  endfunction

  function automatic logic [MagW-1:0] magnitude(coord_t v);
    coord_t a;
    a = (v < 0) ? -v : v;
    return a[MagW-1:0];
  endfunction

  function automatic logic signed [CoordW-1:0] saturate(coord_t v);
    coord_t hi;
    coord_t lo;
    hi = coord_t'((1 << (CoordW - 1)) - 1);
    lo = -hi - coord_t'(1);
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

endpackage

### sv/line_segment_rect_clipper.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper
// Region-code clipping of one segment against a configured rectangle.
// ----------------------------------------------------------------------------
// Usage
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0
//   left, 1 top, 2 width, 3 height. Always ready; write only while idle.
//   Input channel takes one segment request (start and end point, Q12.4).
//   in_ready_o is high only while no segment is being worked on.
//   Output channel gives one intersection request per clipping round and
//   then one final request (accepted segment or rejected) with last_o set.
// Sequencing
//   Each round passes through a decide state, a multiply state, a serial
//   restoring divide over ProdW (36) quotient bits, a fix-up state and an
//   output state; the serial divider dominates. The final request comes from
//   one more decide state after the segment's last round.
// Reset and stalls
//   Reset clears the rectangle to zero and returns the sequencer to idle.
//   While out_ready_i is low the pending request is held and the sequencer
//   waits; nothing is dropped.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lsrc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lsrc_pkg::CoordW-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [lsrc_pkg::CoordW-1:0]   start_x_i,
  input  logic signed [lsrc_pkg::CoordW-1:0]   start_y_i,
  input  logic signed [lsrc_pkg::CoordW-1:0]   end_x_i,
  input  logic signed [lsrc_pkg::CoordW-1:0]   end_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           kind_o,
  output logic signed [lsrc_pkg::CoordW-1:0]   point_x_o,
  output logic signed [lsrc_pkg::CoordW-1:0]   point_y_o,
  output logic signed [lsrc_pkg::CoordW-1:0]   clip_end_x_o,
  output logic signed [lsrc_pkg::CoordW-1:0]   clip_end_y_o,
  output logic                                 last_o
);
  import lsrc_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIX    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state_q, state_d;

  // Rectangle registers
  logic signed [CoordW-1:0] left_q, left_d, top_q, top_d;
  logic [CoordW-2:0]        width_q, width_d, height_q, height_d;

  // Working endpoints, held exactly
  coord_t x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;

  // Operands of the current round
  coord_t          base_q, base_d, edge_q, edge_d;
  logic [MagW-1:0] dm_q, dm_d, nm_q, nm_d, den_q, den_d;
  logic            neg_q, neg_d;
  logic            move1_q, move1_d;   // moving the first endpoint
  logic            edge_y_q, edge_y_d; // edge fixes y, x is interpolated

  // Shared multiply / divide datapath: prod_q holds product, then quotient
  logic [ProdW-1:0] prod_q, prod_d;
  logic [MagW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RoundW-1:0] round_q, round_d;

  // Output register
  logic [1:0]               kind_q, kind_d;
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d, ex_q, ex_d, ey_q, ey_d;
  logic                     last_q, last_d;

  // Edges and region codes
  coord_t     l_w, t_w, r_w, b_w;
  logic [3:0] c1_w, c2_w, co_w;

  assign l_w = coord_t'(left_q);
  assign t_w = coord_t'(top_q);
  assign r_w = l_w + coord_t'({1'b0, width_q});
  assign b_w = t_w + coord_t'({1'b0, height_q});

  assign c1_w = region_code(x1_q, y1_q, l_w, r_w, t_w, b_w);
  assign c2_w = region_code(x2_q, y2_q, l_w, r_w, t_w, b_w);
  assign co_w = (c1_w != 4'd0) ? c1_w : c2_w;

  // Divider step
  logic [MagW:0]   rem_sh;
  logic            ge;
  logic [MagW:0]   rem_sub;
  assign rem_sh  = {rem_q, prod_q[ProdW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Fix-up: signed quotient added to base; zero divisor gives zero
  logic [MagW-1:0] quot;
  coord_t          qs, val;
  assign quot = (den_q == '0) ? '0 : prod_q[MagW-1:0];
  assign qs   = coord_t'({1'b0, quot});
  assign val  = base_q + (neg_q ? -qs : qs);

  // Operand selection for one round
  coord_t dd, nn, dn;
  always_comb begin
    if (co_w[BIT_TOP]) begin
      dd = x2_q - x1_q; nn = t_w - y1_q; dn = y2_q - y1_q;
    end else if (co_w[BIT_BOTTOM]) begin
      dd = x2_q - x1_q; nn = b_w - y1_q; dn = y2_q - y1_q;
    end else if (co_w[BIT_LEFT]) begin
      dd = y2_q - y1_q; nn = l_w - x1_q; dn = x2_q - x1_q;
    end else begin
      dd = y2_q - y1_q; nn = r_w - x1_q; dn = x2_q - x1_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    left_d   = left_q;   top_d    = top_q;
    width_d  = width_q;  height_d = height_q;
    x1_d = x1_q; y1_d = y1_q; x2_d = x2_q; y2_d = y2_q;
    base_d = base_q; edge_d = edge_q;
    dm_d = dm_q; nm_d = nm_q; den_d = den_q;
    neg_d = neg_q; move1_d = move1_q; edge_y_d = edge_y_q;
    prod_d = prod_q; rem_d = rem_q; cnt_d = cnt_q; round_d = round_q;
    kind_d = kind_q; px_d = px_q; py_d = py_q; ex_d = ex_q; ey_d = ey_q;
    last_d = last_q;

    // Config writes, assumed only while idle
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LEFT:   left_d   = cfg_data_i;
        REG_TOP:    top_d    = cfg_data_i;
        REG_WIDTH:  width_d  = cfg_data_i[CoordW-2:0];
        REG_HEIGHT: height_d = cfg_data_i[CoordW-2:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x1_d = coord_t'(start_x_i); y1_d = coord_t'(start_y_i);
          x2_d = coord_t'(end_x_i);   y2_d = coord_t'(end_y_i);
          round_d = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ex_d = '0; ey_d = '0; px_d = '0; py_d = '0;
        if (round_q == RoundW'(MaxRounds) || (c1_w & c2_w) != 4'd0) begin
          kind_d = KIND_REJECT; last_d = 1'b1;
          state_d = ST_OUT;
        end else if ((c1_w | c2_w) == 4'd0) begin
          kind_d = KIND_ACCEPT; last_d = 1'b1;
          px_d = saturate(x1_q); py_d = saturate(y1_q);
          ex_d = saturate(x2_q); ey_d = saturate(y2_q);
          state_d = ST_OUT;
        end else begin
          edge_y_d = co_w[BIT_TOP] | co_w[BIT_BOTTOM];
          base_d   = edge_y_d ? x1_q : y1_q;
          if (co_w[BIT_TOP])         edge_d = t_w;
          else if (co_w[BIT_BOTTOM]) edge_d = b_w;
          else if (co_w[BIT_LEFT])   edge_d = l_w;
          else                       edge_d = r_w;
          move1_d = (c1_w != 4'd0);
          dm_d  = magnitude(dd);
          nm_d  = magnitude(nn);
          den_d = magnitude(dn);
          neg_d = ((dd < 0) ^ (nn < 0)) ^ (dn < 0);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(dm_q) * ProdW'(nm_q);
        rem_d   = '0;
        cnt_d   = CntW'(ProdW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? rem_sub[MagW-1:0] : rem_sh[MagW-1:0];
        prod_d = {prod_q[ProdW-2:0], ge};
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == '0) state_d = ST_FIX;
      end
      ST_FIX: begin
        if (move1_q) begin
          x1_d = edge_y_q ? val : edge_q;
          y1_d = edge_y_q ? edge_q : val;
        end else begin
          x2_d = edge_y_q ? val : edge_q;
          y2_d = edge_y_q ? edge_q : val;
        end
        kind_d = KIND_POINT; last_d = 1'b0;
        px_d = saturate(edge_y_q ? val : edge_q);
        py_d = saturate(edge_y_q ? edge_q : val);
        ex_d = '0; ey_d = '0;
        round_d = round_q + RoundW'(1);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = last_q ? ST_IDLE : ST_DECIDE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      round_q  <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      left_q   <= left_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
      round_q  <= round_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    x1_q <= x1_d; y1_q <= y1_d; x2_q <= x2_d; y2_q <= y2_d;
    base_q <= base_d; edge_q <= edge_d;
    dm_q <= dm_d; nm_q <= nm_d; den_q <= den_d;
    neg_q <= neg_d; move1_q <= move1_d; edge_y_q <= edge_y_d;
    prod_q <= prod_d; rem_q <= rem_d;
    kind_q <= kind_d; px_q <= px_d; py_q <= py_d; ex_q <= ex_d; ey_q <= ey_d;
    last_q <= last_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign kind_o       = kind_q;
  assign point_x_o    = px_q;
  assign point_y_o    = py_q;
  assign clip_end_x_o = ex_q;
  assign clip_end_y_o = ey_q;
  assign last_o       = last_q;

endmodule

### verif/line_segment_rect_clipper_tb.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_tb
// Self-checking bench for the region-code segment clipper. A scoreboard
// predicts every intersection request and the final accept or reject
// request of each segment, and compares them field by field in order.
// Stimulus starts with directed segments, then moves to random segments
// under several rectangles, with random idling on both sides, one long
// output stall and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsrc_pkg::*;

  localparam int     ClkPeriod   = 20;
  localparam int     ResetCycles = 8;
  // Drain margin long enough for a spurious extra round to appear
  localparam int     DrainCycles = 100;
  // Watchdog limit, far above the slowest correct run
  localparam longint LimitCycles = 1_500_000;
  localparam int     RandPhases  = 6;
  localparam int     PhaseItems  = 58;
  localparam int     HoldOff     = 600;
  localparam longint CoordMax    = 32767;
  localparam longint CoordMin    = -32768;

  typedef struct {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic                     last;
  } clip_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the rectangle, clipping predictor, result queue
  // --------------------------------------------------------------------------
  class clip_scoreboard;
    longint       rect_l;
    longint       rect_t;
    longint       rect_w;
    longint       rect_h;
    clip_result_t clip_queue[$];
    int unsigned  mismatches;
    int unsigned  segments;
    int unsigned  n_points;
    int unsigned  n_accepts;
    int unsigned  n_rejects;

    static function logic signed [CoordW-1:0] clamp_coord(longint v);
      if (v > CoordMax) v = CoordMax;
      if (v < CoordMin) v = CoordMin;
      return CoordW'(v);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
      case (idx)
        REG_LEFT:   rect_l = longint'($signed(data));
        REG_TOP:    rect_t = longint'($signed(data));
        REG_WIDTH:  rect_w = longint'(data[CoordW-2:0]);
        REG_HEIGHT: rect_h = longint'(data[CoordW-2:0]);
        default: ;
      endcase
    endfunction

    function logic [3:0] outcode(longint x, longint y, longint l, longint r,
                                 longint t, longint b);
      logic [3:0] c;
      c = '0;
      if (x < l) c[BIT_LEFT] = 1'b1;
      else if (x > r) c[BIT_RIGHT] = 1'b1;
      if (y < t) c[BIT_TOP] = 1'b1;
      else if (y > b) c[BIT_BOTTOM] = 1'b1;
      return c;
    endfunction

    // base + d*n/den, quotient of magnitudes truncated, sign applied after
    function longint lerp(longint base, longint d, longint n, longint den);
      longint q;
      bit     neg;
      neg = ((d < 0) != (n < 0)) != (den < 0);
      if (den == 0) q = 0;
      else q = ((d < 0 ? -d : d) * (n < 0 ? -n : n)) / (den < 0 ? -den : den);
      return base + (neg ? -q : q);
    endfunction

    function void push_result(logic [1:0] kind, longint px, longint py,
                              longint ex, longint ey, logic last);
      clip_result_t res;
      res.kind = kind;
      res.px   = clamp_coord(px);
      res.py   = clamp_coord(py);
      res.ex   = clamp_coord(ex);
      res.ey   = clamp_coord(ey);
      res.last = last;
      clip_queue.push_back(res);
      case (kind)
        KIND_POINT:  n_points++;
        KIND_ACCEPT: n_accepts++;
        default:     n_rejects++;
      endcase
    endfunction

    function void note_segment(logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
                               logic signed [CoordW-1:0] ex, logic signed [CoordW-1:0] ey);
      longint     l, t, r, b, x1, y1, x2, y2, x, y;
      logic [3:0] c1, c2, co;
      int         round;
      bit         decided;
      l  = rect_l;
      t  = rect_t;
      r  = l + rect_w;
      b  = t + rect_h;
      x1 = sx;
      y1 = sy;
      x2 = ex;
      y2 = ey;
      c1 = outcode(x1, y1, l, r, t, b);
      c2 = outcode(x2, y2, l, r, t, b);
      decided = 1'b0;
      segments++;
      for (round = 0; round < MaxRounds && !decided; round++) begin
        if ((c1 | c2) == 4'b0) begin
          push_result(KIND_ACCEPT, x1, y1, x2, y2, 1'b1);
          decided = 1'b1;
        end else if ((c1 & c2) != 4'b0) begin
          push_result(KIND_REJECT, 0, 0, 0, 0, 1'b1);
          decided = 1'b1;
        end else begin
          co = (c1 != 4'b0) ? c1 : c2;
          // edge priority: top, bottom, left, right
          if (co[BIT_TOP]) begin
            x = lerp(x1, x2 - x1, t - y1, y2 - y1);
            y = t;
          end else if (co[BIT_BOTTOM]) begin
            x = lerp(x1, x2 - x1, b - y1, y2 - y1);
            y = b;
          end else if (co[BIT_LEFT]) begin
            y = lerp(y1, y2 - y1, l - x1, x2 - x1);
            x = l;
          end else begin
            y = lerp(y1, y2 - y1, r - x1, x2 - x1);
            x = r;
          end
          if (co == c1) begin
            x1 = x;
            y1 = y;
            c1 = outcode(x1, y1, l, r, t, b);
          end else begin
            x2 = x;
            y2 = y;
            c2 = outcode(x2, y2, l, r, t, b);
          end
          push_result(KIND_POINT, x, y, 0, 0, 1'b0);
        end
      end
      // out of rounds without a decision
      if (!decided) push_result(KIND_REJECT, 0, 0, 0, 0, 1'b1);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(clip_result_t got);
      clip_result_t want;
      if (clip_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected request: expected none, actual kind %0d (%0d,%0d) last %0b",
                 $time, got.kind, got.px, got.py, got.last);
        return;
      end
      want = clip_queue.pop_front();
      compare_field("kind",       longint'(want.kind), longint'(got.kind));
      compare_field("point_x",    longint'(want.px),   longint'(got.px));
      compare_field("point_y",    longint'(want.py),   longint'(got.py));
      compare_field("clip_end_x", longint'(want.ex),   longint'(got.ex));
      compare_field("clip_end_y", longint'(want.ey),   longint'(got.ey));
      compare_field("last",       longint'(want.last), longint'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CoordW-1:0]         cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [CoordW-1:0]  start_x_i;
  logic signed [CoordW-1:0]  start_y_i;
  logic signed [CoordW-1:0]  end_x_i;
  logic signed [CoordW-1:0]  end_y_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [1:0]                kind_o;
  logic signed [CoordW-1:0]  point_x_o;
  logic signed [CoordW-1:0]  point_y_o;
  logic signed [CoordW-1:0]  clip_end_x_o;
  logic signed [CoordW-1:0]  clip_end_y_o;
  logic                      last_o;

  clip_scoreboard sb;

  // idle percentages for each side, and a one-shot receiver stall request
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int unsigned rect_settings;

  line_segment_rect_clipper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .clip_end_x_o (clip_end_x_o),
    .clip_end_y_o (clip_end_y_o),
    .last_o       (last_o)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge only. A long stall requested
  // by the stimulus is counted down here, in cycles, independent of the
  // sender, so the block fills up and drops in_ready_o.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_left       = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Output monitor: a request is taken on the rising edge with valid and ready
  always @(posedge clk_i) begin : watch_results
    clip_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_o;
      got.px   = point_x_o;
      got.py   = point_y_o;
      got.ex   = clip_end_x_o;
      got.ey   = clip_end_y_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // One configuration write; the block is idle whenever this is called
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_rect(logic [CoordW-1:0] l, logic [CoordW-1:0] t,
                          logic [CoordW-1:0] w, logic [CoordW-1:0] h);
    write_cfg(REG_LEFT, l);
    write_cfg(REG_TOP, t);
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
    rect_settings++;
  endtask

  // Offer one segment request. The idle decision is made on the first
  // falling edge after the previous acceptance, so a stale request can
  // never be taken twice and valid is never dropped and raised in one step.
  task automatic send_segment(logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
                              logic signed [CoordW-1:0] ex, logic signed [CoordW-1:0] ey);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_segment(sx, sy, ex, ey);
  endtask

  // Withdraw the input and hold off until every predicted result has come
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.clip_queue.size() != 0) @(posedge clk_i);
  endtask

  // Mostly coordinates around the rectangle (so segments cross edges), some
  // exactly on an edge, and some anywhere in the full range.
  function automatic logic signed [CoordW-1:0] pick_coord(longint lo, longint hi);
    longint      span, a, z;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return CoordW'($urandom());
    if (sel < 22) return clip_scoreboard::clamp_coord($urandom_range(0, 1) ? lo : hi);
    span = hi - lo;
    a = lo - span / 2 - 32;
    z = hi + span / 2 + 32;
    if (a < CoordMin) a = CoordMin;
    if (z > CoordMax) z = CoordMax;
    return CoordW'(a + longint'($urandom_range(0, int'(z - a))));
  endfunction

  task automatic send_random_segment();
    longint l, r, t, b;
    l = sb.rect_l;
    r = l + sb.rect_w;
    t = sb.rect_t;
    b = t + sb.rect_h;
    send_segment(pick_coord(l, r), pick_coord(t, b), pick_coord(l, r), pick_coord(t, b));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int k;
    sb              = new;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_LEFT;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    start_x_i       = '0;
    start_y_i       = '0;
    end_x_i         = '0;
    end_y_i         = '0;
    send_idle_pct   = 28;
    recv_idle_pct   = 88;
    hold_off_cycles = 0;
    rect_settings   = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset rectangle is a single point at the origin
    send_segment(0, 0, 0, 0);
    send_segment(-100, -100, 100, 100);
    send_segment(-100, 0, 100, 0);

    // Ordinary rectangle: x -100..100, y -50..50 in Q12.4
    wait_drained();
    set_rect(-1600, -800, 3200, 1600);
    send_segment(0, 0, 100, -100);            // fully inside
    send_segment(-2000, 0, -3000, 100);       // both left of the box
    send_segment(0, 0, 0, -2000);             // leaves through the top
    send_segment(100, 0, 300, 2000);          // leaves through the bottom
    send_segment(0, 0, -5000, 300);           // leaves through the left
    send_segment(0, 0, 5000, -300);           // leaves through the right
    send_segment(-5000, -3000, 5000, 3000);   // crosses, both ends clipped
    send_segment(-3000, 0, 0, -3000);         // passes the corner outside
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-1600, -800, 1600, 800);     // ends on the corners
    send_segment(2000, 2000, 2000, 2000);     // point outside
    send_segment(5, 5, 5, 5);                 // point inside

    // Empty rectangle: zero width, edges count as inside
    wait_drained();
    set_rect(0, -100, 0, 200);
    send_segment(-100, 0, 100, 0);
    send_segment(-100, -200, 100, 200);

    // Right and bottom edges beyond the coordinate range
    wait_drained();
    set_rect(32767, 32767, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(32767, -32768, 32767, 32767);

    // Long output stall while the sender keeps offering: the block fills
    // and holds in_ready_o low until the receiver lets go
    wait_drained();
    set_rect(-1600, -800, 3200, 1600);
    hold_off_cycles = HoldOff;
    repeat (8) send_random_segment();

    for (phase = 0; phase < RandPhases; phase++) begin
      wait_drained();
      case (phase)
        0: set_rect(-1600, -800, 3200, 1600);
        1: set_rect(16'sh7fff, 16'sh7fff, 16'h7fff, 16'h7fff);
        2: set_rect(16'sh8000, 16'sh8000, 16'h7fff, 16'h7fff);
        3: set_rect(800, -2400, 0, 4800);
        4: set_rect(-4000, 1200, 8000, 0);
        default: set_rect(CoordW'($urandom()), CoordW'($urandom()),
                          CoordW'($urandom()), CoordW'($urandom()));
      endcase
      // sender idles lightly first, then heavily, then neither side idles
      case (phase / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < PhaseItems; k++) begin
        // in the first phase only, the sender pauses midway until every result is back
        if (phase == 0 && k == PhaseItems / 2) wait_drained();
        send_random_segment();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d segments under %0d rectangle settings with random idling and stalls",
             sb.segments, rect_settings);
    $display("Results: %0d intersection points, %0d accepted, %0d rejected, %0d mismatches",
             sb.n_points, sb.n_accepts, sb.n_rejects, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** line_segment_rect_clipper: PASSED **");
    end else begin
      $display("** line_segment_rect_clipper: FAILED **");
    end
    $finish;
  end

  // Safety net against a hang
  initial begin : watchdog
    #(LimitCycles * ClkPeriod);
    $display("%0t: timeout with %0d results outstanding", $time, sb.clip_queue.size());
    $display("** line_segment_rect_clipper: FAILED **");
    $finish;
  end

endmodule
